>>> sv/sfd_pkg.sv
// sfd_pkg: shared types and constants for the serial frame deframer
// depends on nothing; imported by the front, queue, back and top modules
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    // header bytes of a frame
    localparam logic [7:0] HDR0 = 8'hFF;
    localparam logic [7:0] HDR1 = 8'hCC;

    // frame event queue depth and pointer width
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_CODE_RESPONSE = 2'd0;
    localparam logic [1:0] CFG_CODE_VOLTAGE  = 2'd1;
    localparam logic [1:0] CFG_CODE_ENCODER  = 2'd2;

    // frame status codes as reported on frame_status
    localparam logic [2:0] ST_VOLTAGE = 3'd0;
    localparam logic [2:0] ST_ENCODER = 3'd1;
    localparam logic [2:0] ST_OTHER   = 3'd2;
    localparam logic [2:0] ST_BAD_SUM = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;

    // end-of-frame event handed from the parser to the classifier
    typedef struct packed {
        logic            malformed;  // length byte below two
        logic            sum_ok;     // checksum byte matched the running sum
        logic            len_ge3;    // payload long enough for a voltage frame
        logic            len_ge5;    // payload long enough for an encoder frame
        logic [7:0]      code;       // function code, zero if malformed
        logic [3:0][7:0] fields;     // payload bytes 1 to 4
    } sfd_evt_t;

endpackage

`default_nettype wire

>>> sv/sfd_front.sv
// sfd_front: byte-level frame parser, pushes one event per finished or malformed frame
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_front
    import sfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_take,
    input  wire logic [7:0] byte_in,
    output sfd_evt_t        evt,
    output logic            evt_push
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_GOT_FF  = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_SUM     = 3'd4;

    logic [2:0]      phase_reg, phase_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      seen_reg, seen_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      code_reg, code_next;
    logic [3:0][7:0] fields_reg, fields_next;
    logic [8:0]      seen_plus2;
    logic [1:0]      seen_minus1;

    assign seen_plus2  = {1'b0, seen_reg} + 9'd2;
    assign seen_minus1 = seen_reg[1:0] - 2'd1;

    // parser next state and event generation
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        code_next   = code_reg;
        fields_next = fields_reg;
        evt_push    = 1'b0;
        evt         = '0;
        evt.code    = code_reg;
        evt.fields  = fields_reg;
        evt.sum_ok  = (byte_in == sum_reg);
        evt.len_ge3 = (seen_reg >= 8'd3);
        evt.len_ge5 = (seen_reg >= 8'd5);
        if (byte_take)
        begin
            case (phase_reg)
                PH_GOT_FF:
                begin
                    if (byte_in == HDR1)
                        phase_next = PH_LEN;
                    else if (byte_in == HDR0)
                        phase_next = PH_GOT_FF;
                    else
                        phase_next = PH_HUNT;
                end
                PH_LEN:
                begin
                    len_next    = '0;
                    seen_next   = '0;
                    sum_next    = '0;
                    code_next   = '0;
                    fields_next = '0;
                    if (byte_in < 8'd2)
                    begin
                        phase_next    = PH_HUNT;
                        evt_push      = 1'b1;
                        evt           = '0;
                        evt.malformed = 1'b1;
                    end
                    else
                    begin
                        len_next   = byte_in;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (seen_reg == 8'd0)
                        code_next = byte_in;
                    else if (seen_reg <= 8'd4)
                        fields_next[seen_minus1] = byte_in;
                    sum_next  = sum_reg + byte_in;
                    seen_next = seen_reg + 8'd1;
                    if (seen_plus2 >= {1'b0, len_reg})
                        phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    phase_next = PH_HUNT;
                    evt_push   = 1'b1;
                end
                default:
                begin
                    phase_next = (byte_in == HDR0) ? PH_GOT_FF : PH_HUNT;
                end
            endcase
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            len_reg    <= '0;
            seen_reg   <= '0;
            sum_reg    <= '0;
            code_reg   <= '0;
            fields_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            code_reg   <= code_next;
            fields_reg <= fields_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/sfd_queue.sv
// sfd_queue: short queue of frame events between parser and classifier
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_queue
    import sfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire sfd_evt_t push_data,
    input  wire logic     pop,
    output sfd_evt_t      pop_data,
    output logic          full,
    output logic          not_empty
);

    sfd_evt_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    // pointer wrap helper
    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + QPTR_W'(1);
    endfunction

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> sv/sfd_back.sv
// sfd_back: code registers, frame classification and the result register
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfd_back
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire sfd_evt_t    evt,
    input  wire logic        evt_avail,
    output logic             evt_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       frame_status,
    output logic [7:0]       function_code,
    output logic [15:0]      millivolts,
    output logic [3:0][7:0]  counts
);

    logic [7:0]      code_response_reg, code_voltage_reg, code_encoder_reg;
    logic            valid_reg;
    logic [2:0]      status_reg, status_next;
    logic [7:0]      fcode_reg;
    logic [15:0]     mv_reg, mv_next;
    logic [3:0][7:0] counts_reg, counts_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_response_reg <= 8'd1;
            code_voltage_reg  <= 8'd2;
            code_encoder_reg  <= 8'd3;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CODE_RESPONSE: code_response_reg <= cfg_data;
                CFG_CODE_VOLTAGE:  code_voltage_reg  <= cfg_data;
                CFG_CODE_ENCODER:  code_encoder_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // take an event when the result register is empty or being drained
    assign evt_pop = evt_avail && (!valid_reg || !out_stall);

    // classify the event against the configured codes
    always_comb
    begin
        status_next = ST_OTHER;
        mv_next     = '0;
        counts_next = '0;
        if (evt.malformed)
            status_next = ST_SHORT;
        else if (!evt.sum_ok)
            status_next = ST_BAD_SUM;
        else if (evt.code == code_response_reg || evt.code == code_voltage_reg)
        begin
            if (!evt.len_ge3)
                status_next = ST_SHORT;
            else
            begin
                status_next = ST_VOLTAGE;
                mv_next     = {evt.fields[1], evt.fields[0]};
            end
        end
        else if (evt.code == code_encoder_reg)
        begin
            if (!evt.len_ge5)
                status_next = ST_SHORT;
            else
            begin
                status_next = ST_ENCODER;
                counts_next = evt.fields;
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (evt_pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (evt_pop)
        begin
            status_reg <= status_next;
            fcode_reg  <= evt.code;
            mv_reg     <= mv_next;
            counts_reg <= counts_next;
        end
    end

    assign out_valid     = valid_reg;
    assign frame_status  = status_reg;
    assign function_code = fcode_reg;
    assign millivolts    = mv_reg;
    assign counts        = counts_reg;

endmodule

`default_nettype wire

>>> sv/serial_frame_deframer_unit.sv
// serial_frame_deframer_unit: top level of the serial frame deframer
// depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
//
// usage:
//  - input channel: in_valid / in_stall / rx_byte, one received byte per
//    transaction; a transaction completes when in_valid is high and in_stall low
//  - frames look like FF CC L P0 .. P(L-2) C; C is the mod-256 sum of P0..P(L-2)
//  - output channel: out_valid / out_stall and the result fields; one result per
//    frame end (checksum byte), or per length byte below two (malformed)
//  - config port: cfg_write with cfg_index 0 response code, 1 voltage code,
//    2 encoder code; index 3 is ignored; write only while the block is idle
//  - throughput: one byte per cycle while in_stall is low
//  - the byte that ends the frame becomes an event in the event queue, which is
//    then classified into the result register that drives out_valid
//  - a two-entry event queue sits between parser and classifier; when the
//    receiver stalls, results back up into the queue and in_stall rises only
//    once the queue is full
//  - reset: parser back to hunting, queue and result emptied, codes 1, 2, 3
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_unit
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       frame_status,
    output logic [7:0]       function_code,
    output logic [15:0]      millivolts,
    output logic signed [7:0] wheel_count_a,
    output logic signed [7:0] wheel_count_b,
    output logic signed [7:0] wheel_count_c,
    output logic signed [7:0] wheel_count_d
);

    sfd_evt_t        push_evt, pop_evt;
    logic            push, pop, q_full, q_avail, byte_take;
    logic [3:0][7:0] counts;

    // input transaction
    assign in_stall  = q_full;
    assign byte_take = in_valid && !in_stall;

    // front end parser
    sfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .byte_in   (rx_byte),
        .evt       (push_evt),
        .evt_push  (push)
    );

    // event queue
    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_evt),
        .pop       (pop),
        .pop_data  (pop_evt),
        .full      (q_full),
        .not_empty (q_avail)
    );

    // back end classifier and result register
    sfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .evt           (pop_evt),
        .evt_avail     (q_avail),
        .evt_pop       (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_status  (frame_status),
        .function_code (function_code),
        .millivolts    (millivolts),
        .counts        (counts)
    );

    assign wheel_count_a = $signed(counts[0]);
    assign wheel_count_b = $signed(counts[1]);
    assign wheel_count_c = $signed(counts[2]);
    assign wheel_count_d = $signed(counts[3]);

endmodule

`default_nettype wire
